### rtl/tcbaa_pkg.sv
package tcbaa_pkg;

   // Default number of users per class; also bounds occupants plus waiters.
   localparam int USERS_PER_CLASS_DEF = 16;

   // Most grants that one emptying exit may issue.
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Field widths of the transaction payloads.
   localparam int LIMIT_W     = 8;
   localparam int RUN_W       = 8;
   localparam int OCC_FIELD_W = 5;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   localparam logic [RUN_W-1:0]   RUN_MAX     = '1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

   // Request operation codes.
   localparam logic OP_ENTER = 1'b0;
   localparam logic OP_EXIT  = 1'b1;

endpackage

### rtl/two_class_batch_admission_arbiter_top.sv
// An enter that is granted at once passes through the evaluate, grant and look-ahead
// states before rsp_tvalid rises. Each further grant of an emptying exit passes again
// through the grant and look-ahead states after the previous one is taken. One request
// is handled at a time: req_tready is high only while the sequencer is idle.
// Reset is synchronous and active high: all counts clear and batch_limit returns to 4.
module two_class_batch_admission_arbiter_top #(
   parameter int USERS_PER_CLASS = tcbaa_pkg::USERS_PER_CLASS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel. req_tdata fields from bit 0 up: op, user_class, zero fill.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tcbaa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Result channel. rsp_tdata fields from bit 0 up: granted_class, occupancy, zero fill.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tcbaa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser fields from bit 0 up: error.
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   // Configuration: batch_limit.
   input  logic                               csr_we,
   input  logic [tcbaa_pkg::LIMIT_W-1:0]      csr_wdata
);

   // Counts hold 0 .. USERS_PER_CLASS.
   localparam int CNT_W = $clog2(USERS_PER_CLASS + 1);
   localparam logic [CNT_W:0] FULL_LEVEL = (CNT_W + 1)'(USERS_PER_CLASS);
   localparam logic [tcbaa_pkg::RES_CNT_W-1:0] RES_CAP =
      tcbaa_pkg::RES_CNT_W'(tcbaa_pkg::MAX_RESULTS);

   // The sequencer walks one request through evaluate, grant and look-ahead steps.
   // An emptying exit loops through grant, look-ahead and output once per admitted waiter.
   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_CHECK,
      S_GRANT,
      S_LOOK,
      S_OUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   occ_ff  [2];
   logic [CNT_W-1:0]                   occ_in  [2];
   logic [CNT_W-1:0]                   wait_ff [2];
   logic [CNT_W-1:0]                   wait_in [2];
   logic [tcbaa_pkg::RUN_W-1:0]        run_ff  [2];
   logic [tcbaa_pkg::RUN_W-1:0]        run_in  [2];
   logic [tcbaa_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic                               op_ff, op_in;
   logic                               cls_ff, cls_in;
   logic                               drain_ff, drain_in;
   logic [tcbaa_pkg::RES_CNT_W-1:0]    n_ff, n_in;
   logic                               rsp_cls_ff, rsp_cls_in;
   logic [tcbaa_pkg::OCC_FIELD_W-1:0]  rsp_occ_ff, rsp_occ_in;
   logic                               rsp_err_ff, rsp_err_in;
   logic                               rsp_last_ff, rsp_last_in;

   // Shared evaluation unit, always looking at the class held in cls_ff.
   logic                               oth;
   logic                               may_admit;
   logic                               is_full;
   logic [CNT_W:0]                     sum_cnt;
   logic [CNT_W+tcbaa_pkg::OCC_FIELD_W-1:0] occ_wide;
   logic [tcbaa_pkg::OCC_FIELD_W-1:0]  occ_field;

   assign oth       = ~cls_ff;
   assign may_admit = (occ_ff[oth] == '0) &&
                      !((run_ff[cls_ff] >= limit_ff) && (wait_ff[oth] != '0));
   assign sum_cnt   = {1'b0, occ_ff[cls_ff]} + {1'b0, wait_ff[cls_ff]};
   assign is_full   = (sum_cnt >= FULL_LEVEL);
   // The occupancy field carries the count modulo 32.
   assign occ_wide  = {{tcbaa_pkg::OCC_FIELD_W{1'b0}}, occ_ff[cls_ff]};
   assign occ_field = occ_wide[tcbaa_pkg::OCC_FIELD_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {{(tcbaa_pkg::RSP_DATA_W - 1 - tcbaa_pkg::OCC_FIELD_W){1'b0}},
                        rsp_occ_ff, rsp_cls_ff};
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in    = state_ff;
      occ_in      = occ_ff;
      wait_in     = wait_ff;
      run_in      = run_ff;
      limit_in    = csr_we ? csr_wdata : limit_ff;
      op_in       = op_ff;
      cls_in      = cls_ff;
      drain_in    = drain_ff;
      n_in        = n_ff;
      rsp_cls_in  = rsp_cls_ff;
      rsp_occ_in  = rsp_occ_ff;
      rsp_err_in  = rsp_err_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[0];
               cls_in   = req_tdata[1];
               drain_in = 1'b0;
               n_in     = '0;
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            if (op_ff == tcbaa_pkg::OP_ENTER) begin
               if (is_full) begin
                  // Waiter overflow: report the current occupancy, change nothing.
                  rsp_cls_in  = cls_ff;
                  rsp_occ_in  = occ_field;
                  rsp_err_in  = 1'b1;
                  rsp_last_in = 1'b1;
                  state_in    = S_OUT;
               end else begin
                  wait_in[cls_ff] = wait_ff[cls_ff] + CNT_W'(1);
                  state_in        = may_admit ? S_GRANT : S_IDLE;
               end
            end else begin
               if (occ_ff[cls_ff] == '0) begin
                  // Exit from an empty class.
                  rsp_cls_in  = cls_ff;
                  rsp_occ_in  = '0;
                  rsp_err_in  = 1'b1;
                  rsp_last_in = 1'b1;
                  state_in    = S_OUT;
               end else begin
                  occ_in[cls_ff] = occ_ff[cls_ff] - CNT_W'(1);
                  if (occ_ff[cls_ff] == CNT_W'(1)) begin
                     // Class emptied: start admitting waiters of the other class.
                     cls_in   = oth;
                     drain_in = 1'b1;
                     state_in = S_CHECK;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end

         S_CHECK: begin
            state_in = ((wait_ff[cls_ff] != '0) && may_admit) ? S_GRANT : S_IDLE;
         end

         S_GRANT: begin
            occ_in[cls_ff] = occ_ff[cls_ff] + CNT_W'(1);
            if (wait_ff[cls_ff] != '0) begin
               wait_in[cls_ff] = wait_ff[cls_ff] - CNT_W'(1);
            end
            run_in[oth] = '0;
            if ((wait_ff[oth] != '0) && (run_ff[cls_ff] != tcbaa_pkg::RUN_MAX)) begin
               run_in[cls_ff] = run_ff[cls_ff] + tcbaa_pkg::RUN_W'(1);
            end
            n_in     = n_ff + tcbaa_pkg::RES_CNT_W'(1);
            state_in = S_LOOK;
         end

         S_LOOK: begin
            // Decide now whether another grant follows, so this result knows its tlast.
            rsp_cls_in  = cls_ff;
            rsp_occ_in  = occ_field;
            rsp_err_in  = 1'b0;
            rsp_last_in = !(drain_ff && (n_ff < RES_CAP) &&
                            (wait_ff[cls_ff] != '0) && may_admit);
            state_in    = S_OUT;
         end

         S_OUT: begin
            if (rsp_tready) begin
               state_in = rsp_last_ff ? S_IDLE : S_GRANT;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         occ_ff[0]  <= '0;
         occ_ff[1]  <= '0;
         wait_ff[0] <= '0;
         wait_ff[1] <= '0;
         run_ff[0]  <= '0;
         run_ff[1]  <= '0;
         limit_ff   <= tcbaa_pkg::LIMIT_RESET;
         drain_ff   <= 1'b0;
         n_ff       <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         wait_ff  <= wait_in;
         run_ff   <= run_in;
         limit_ff <= limit_in;
         drain_ff <= drain_in;
         n_ff     <= n_in;
      end
      op_ff       <= op_in;
      cls_ff      <= cls_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_occ_ff  <= rsp_occ_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

### bench/two_class_batch_admission_arbiter_top_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the two-class batch admission arbiter.
// Requests are driven on the req_ stream and results taken from the rsp_ stream.
// A behavioral copy of the arbiter runs beside the block. Each accepted request
// is fed to it, and the grants it predicts wait in a queue. Every rsp_
// transaction is checked against the oldest waiting grant.
module two_class_batch_admission_arbiter_top_tb;

   // Longest stretch without any accepted transaction before the run is declared hung.
   // The longest legal stretch is the deliberate receiver hold-off of the
   // back-pressure test.
   localparam int STALL_LIMIT = 2000;
   // Quiet cycles after the last expected grant. A request that causes no
   // result may still be in flight.
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_OFF_CYCLES = 300;

   // One result transaction as the bench expects it.
   typedef struct packed {
      logic                              cls;
      logic [tcbaa_pkg::OCC_FIELD_W-1:0] occ;
      logic                              err;
      logic                              last;
   } grant_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [tcbaa_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [tcbaa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                       rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_we;
   logic [tcbaa_pkg::LIMIT_W-1:0]    csr_wdata;

   // Shadow copy of the arbiter's counters and its one register.
   logic [tcbaa_pkg::OCC_FIELD_W-1:0] occ_cnt [2];
   logic [tcbaa_pkg::OCC_FIELD_W-1:0] wait_cnt [2];
   logic [tcbaa_pkg::RUN_W-1:0]       run_cnt [2];
   logic [tcbaa_pkg::LIMIT_W-1:0]     batch_limit;

   grant_type expected_grants [$];

   int error_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int stall_cycles;

   two_class_batch_admission_arbiter_top #(
      .USERS_PER_CLASS(tcbaa_pkg::USERS_PER_CLASS_DEF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // A class may be admitted when the other class holds nothing and the class has
   // not used up its batch while the other class is waiting.
   function automatic logic can_admit(input logic cls);
      logic oth;
      oth = ~cls;
      if (occ_cnt[oth] != 0)
         return 1'b0;
      if (run_cnt[cls] >= batch_limit && wait_cnt[oth] != 0)
         return 1'b0;
      return 1'b1;
   endfunction

   // One admission: the class gains an occupant and loses a waiter. The other class's
   // run restarts. The class's own run grows only while the other class still waits,
   // and it saturates at the top of its range.
   function automatic void admit_one(input logic cls);
      logic oth;
      oth = ~cls;
      occ_cnt[cls] = occ_cnt[cls] + 1'b1;
      if (wait_cnt[cls] != 0)
         wait_cnt[cls] = wait_cnt[cls] - 1'b1;
      run_cnt[oth] = '0;
      if (wait_cnt[oth] != 0 && run_cnt[cls] != tcbaa_pkg::RUN_MAX)
         run_cnt[cls] = run_cnt[cls] + 1'b1;
   endfunction

   function automatic void record_grant(input logic cls,
                                        input logic [tcbaa_pkg::OCC_FIELD_W-1:0] occ,
                                        input logic err, input logic last);
      grant_type g;
      g.cls  = cls;
      g.occ  = occ;
      g.err  = err;
      g.last = last;
      expected_grants.push_back(g);
   endfunction

   // Works out the results of one accepted request and advances the shadow counters.
   function automatic void predict_grants(input logic op, input logic cls);
      logic oth;
      logic more;
      int   n;
      oth = ~cls;
      n   = 0;
      if (op == tcbaa_pkg::OP_ENTER) begin
         // A class that is full with occupants and waiters refuses the newcomer.
         if (int'(occ_cnt[cls]) + int'(wait_cnt[cls]) >= tcbaa_pkg::USERS_PER_CLASS_DEF) begin
            record_grant(cls, occ_cnt[cls], 1'b1, 1'b1);
            return;
         end
         wait_cnt[cls] = wait_cnt[cls] + 1'b1;
         if (can_admit(cls)) begin
            admit_one(cls);
            record_grant(cls, occ_cnt[cls], 1'b0, 1'b1);
         end
         return;
      end
      // Leaving an empty class is refused and reports zero occupants.
      if (occ_cnt[cls] == 0) begin
         record_grant(cls, '0, 1'b1, 1'b1);
         return;
      end
      occ_cnt[cls] = occ_cnt[cls] - 1'b1;
      if (occ_cnt[cls] != 0)
         return;
      // The class has emptied: hand the resource over to the other class's waiters.
      more = wait_cnt[oth] != 0 && can_admit(oth);
      while (more) begin
         admit_one(oth);
         n++;
         more = n < tcbaa_pkg::MAX_RESULTS && wait_cnt[oth] != 0 && can_admit(oth);
         record_grant(oth, occ_cnt[oth], 1'b0, !more);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Result checking, receiver and watchdog
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            $error("unexpected result: granted_class %0d occupancy %0d error %0d last %0d",
                   rsp_tdata[0], rsp_tdata[5:1], rsp_tuser[0], rsp_tlast);
            error_count++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_tdata[0] !== want.cls) begin
               $error("granted_class: expected %0d, got %0d", want.cls, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[5:1] !== want.occ) begin
               $error("occupancy: expected %0d, got %0d", want.occ, rsp_tdata[5:1]);
               error_count++;
            end
            if (rsp_tuser[0] !== want.err) begin
               $error("error: expected %0d, got %0d", want.err, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // The receiver stalls at random, or for a whole hold-off stretch when a test
   // loads one.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Any accepted transaction on either stream restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------

   // Offers one request after a random gap, waits for the handshake and predicts
   // its results. tvalid stays high on return, so back-to-back requests need no
   // second assignment in the same time step.
   task automatic offer_request(input logic op, input logic cls);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(tcbaa_pkg::REQ_DATA_W-2){1'b0}}, cls, op};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_grants(op, cls);
   endtask

   // Stops offering and waits until every predicted grant has arrived. Then the
   // bench waits out the tail of a request that produces no result.
   task automatic drain_grants();
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The register is only written while the arbiter is idle.
   task automatic write_batch_limit(input logic [tcbaa_pkg::LIMIT_W-1:0] value);
      drain_grants();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      batch_limit = value;
   endtask

   // Lets every occupant leave. Waiters that get admitted on the way leave too.
   task automatic settle_occupants();
      int guard;
      guard = 0;
      while ((occ_cnt[0] != 0 || occ_cnt[1] != 0) && guard < 100) begin
         offer_request(tcbaa_pkg::OP_EXIT, (occ_cnt[0] != 0) ? 1'b0 : 1'b1);
         guard++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Runs at the reset limit. It covers exits from empty classes, an immediate
   // grant, an enter that has to wait, the handover on an emptying exit, and an
   // emptying exit with nobody waiting.
   task automatic test_refusals_and_handover();
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b1);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b1);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b1);
   endtask

   // With a batch of one, class 0 gets one extra admission while class 1 waits.
   // Its next enter must queue, and the turn passes over on each emptying exit.
   task automatic test_batch_limit_turns();
      write_batch_limit(8'd1);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b1);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b1);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
   endtask

   // A limit of zero blocks both classes once both have waiters, and the emptying
   // exit then admits nobody. Raising the limit to its top value lets a fresh enter
   // break the deadlock, and the waiters are then served in turns.
   task automatic test_deadlock_and_recovery();
      write_batch_limit(8'd0);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b1);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      write_batch_limit(8'd255);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b1);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b1);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b1);
   endtask

   // Fills class 1 with sixteen waiters behind one class 0 occupant. The emptying
   // exit then releases the longest burst of grants while the receiver holds off.
   // The sender keeps offering, so the block backs up and stalls its input. The
   // overflow enter afterwards reports a full class of sixteen.
   task automatic test_backpressure_full_burst();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle_occupants();
      write_batch_limit(tcbaa_pkg::LIMIT_RESET);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      repeat (tcbaa_pkg::USERS_PER_CLASS_DEF) offer_request(tcbaa_pkg::OP_ENTER, 1'b1);
      hold_left <= HOLD_OFF_CYCLES;
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b1);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      repeat (tcbaa_pkg::USERS_PER_CLASS_DEF) offer_request(tcbaa_pkg::OP_EXIT, 1'b1);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
   endtask

   // Mostly plausible traffic: enters, and exits of classes that hold occupants,
   // preferring the occupied class so that emptying exits hand over often. About
   // one request in five is arbitrary noise, which adds refused exits and overflows.
   task automatic test_random_traffic(input int count,
                                      input logic [tcbaa_pkg::LIMIT_W-1:0] limit);
      logic op;
      logic cls;
      write_batch_limit(limit);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 20) begin
            op  = 1'($urandom_range(1));
            cls = 1'($urandom_range(1));
         end else begin
            cls = 1'($urandom_range(1));
            if (occ_cnt[cls] == 0 && occ_cnt[~cls] != 0 && $urandom_range(1) == 1)
               cls = ~cls;
            op = (occ_cnt[cls] != 0 && $urandom_range(99) < 50) ?
                 tcbaa_pkg::OP_EXIT : tcbaa_pkg::OP_ENTER;
         end
         offer_request(op, cls);
      end
   endtask

   // With a limit of eight, class 0 keeps one occupant while entering and leaving
   // over and over, and class 1 waits the whole time. The run count climbs to the
   // limit, class 0 is then held back, and class 1 finally gets its turn.
   task automatic test_run_limit_ceiling();
      settle_occupants();
      write_batch_limit(8'd8);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
      offer_request(tcbaa_pkg::OP_ENTER, 1'b1);
      repeat (10) begin
         offer_request(tcbaa_pkg::OP_ENTER, 1'b0);
         offer_request(tcbaa_pkg::OP_EXIT, 1'b0);
      end
      settle_occupants();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      error_count   = 0;
      hold_left     = 0;
      stall_cycles  = 0;
      send_idle_pct = 21;
      recv_idle_pct = 64;
      batch_limit   = tcbaa_pkg::LIMIT_RESET;
      for (int c = 0; c < 2; c++) begin
         occ_cnt[c]  = '0;
         wait_cnt[c] = '0;
         run_cnt[c]  = '0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The sender idles a little and the receiver a lot.
      test_refusals_and_handover();
      test_batch_limit_turns();
      test_deadlock_and_recovery();
      test_random_traffic(10, 8'($urandom_range(1, 3)));

      // The roles are swapped: the sender idles a lot and the receiver a little.
      send_idle_pct = 64;
      recv_idle_pct = 21;
      test_random_traffic(10, 8'($urandom_range(4, 8)));

      // From here on, neither side idles.
      test_backpressure_full_burst();
      test_random_traffic(6, 8'd2);
      test_run_limit_ceiling();

      drain_grants();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
